### rtl/atre_pkg.sv
`default_nettype none

package atre_pkg;

  // configuration port
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_AUTOWRAP = 3'd0,
    REG_BS_ERASE = 3'd1,
    REG_CR_LF    = 3'd2,
    REG_LF_CR    = 3'd3,
    REG_NORM_FG  = 3'd4,
    REG_NORM_BG  = 3'd5,
    REG_PALETTE  = 3'd6
  } reg_e;

  // register reset values
  localparam logic [7:0] NORM_FG_RST = 8'hFF;
  localparam logic [7:0] NORM_BG_RST = 8'h01;

  // parser phase
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_e;

  // screen action codes
  localparam int ACTION_W = 4;
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 4'd0,
    ACT_DRAW      = 4'd1,
    ACT_BEEP      = 4'd2,
    ACT_CLR_EOL   = 4'd3,
    ACT_CLR_BOL   = 4'd4,
    ACT_CLR_LINE  = 4'd5,
    ACT_CLR_EOS   = 4'd6,
    ACT_CLR_BOS   = 4'd7,
    ACT_CLR_SCRN  = 4'd8
  } action_e;

  // control bytes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_FINAL = 8'h40;
  localparam logic [7:0] CH_LBRK  = 8'h5B;

  // CSI finals
  localparam logic [7:0] FN_CUU = 8'h41; // A
  localparam logic [7:0] FN_CUD = 8'h42; // B
  localparam logic [7:0] FN_CUF = 8'h43; // C
  localparam logic [7:0] FN_CUB = 8'h44; // D
  localparam logic [7:0] FN_CUP = 8'h48; // H
  localparam logic [7:0] FN_ED  = 8'h4A; // J
  localparam logic [7:0] FN_EL  = 8'h4B; // K
  localparam logic [7:0] FN_SU  = 8'h53; // S
  localparam logic [7:0] FN_SM  = 8'h68; // h
  localparam logic [7:0] FN_RM  = 8'h6C; // l
  localparam logic [7:0] FN_SGR = 8'h6D; // m
  localparam logic [7:0] FN_SCP = 8'h73; // s
  localparam logic [7:0] FN_RCP = 8'h75; // u

  // parameter values
  localparam logic [15:0] PV_CURSOR   = 16'd25;
  localparam logic [15:0] PV_REVERSE  = 16'd7;
  localparam logic [15:0] PV_FG_LO    = 16'd30;
  localparam logic [15:0] PV_FG_HI    = 16'd37;
  localparam logic [15:0] PV_FG_EXT   = 16'd38;
  localparam logic [15:0] PV_BG_LO    = 16'd40;
  localparam logic [15:0] PV_BG_HI    = 16'd47;
  localparam logic [15:0] PV_BG_EXT   = 16'd48;
  localparam logic [15:0] PV_IDX_MODE = 16'd5;
  localparam logic [15:0] PV_SAT      = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/ansi_terminal_rx_engine_core.sv
`default_nettype none

// ANSI terminal receive engine.
// Input channel: one received byte per word (rx_byte_i) with in_valid_i /
// in_stall_o. Output channel: one screen action per byte (draw a glyph,
// beep, one of the clears, scroll count) plus the new cursor, with
// out_valid_o / out_stall_i. A word moves when valid is high and stall low.
//
// Pipeline: an input register, then one pass of decode logic that updates
// the parser and cursor state and loads the result register, which raises
// out_valid_o (two register stages); throughput is one byte per cycle while
// out_stall_i holds no result, set by the single state-update pass.
//
// Stall: while out_stall_i holds a result, the result register keeps its
// word and the input register can take one more byte; in_stall_o rises
// only once both are full.
//
// Reset (rst_ni low, async): parser back to text, parameters cleared,
// cursor and saved cursor at 0,0, colors 255/1, cursor shown, config
// registers at their reset values, both pipeline registers empty.
// Config is an APB port (8-byte register stride, pready tied high);
// write it only while the engine is idle.

module ansi_terminal_rx_engine_core #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 30,
  parameter int MAX_PARAMS     = 5,
  localparam int COL_W = $clog2(SCREEN_COLUMNS),
  localparam int ROW_W = $clog2(SCREEN_ROWS)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // APB config
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [atre_pkg::CFG_AW-1:0]        paddr,
  input  wire  [atre_pkg::CFG_DW-1:0]        pwdata,
  output logic [atre_pkg::CFG_DW-1:0]        prdata,
  output logic                               pready,
  // byte input
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [7:0]                         rx_byte_i,
  // result output
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [atre_pkg::ACTION_W-1:0]      action_o,
  output logic [7:0]                         glyph_o,
  output logic [COL_W-1:0]                   draw_col_o,
  output logic [ROW_W-1:0]                   draw_row_o,
  output logic [7:0]                         draw_fg_o,
  output logic [7:0]                         draw_bg_o,
  output logic [ROW_W-1:0]                   scroll_lines_o,
  output logic [COL_W-1:0]                   cursor_col_o,
  output logic [ROW_W-1:0]                   cursor_row_o,
  output logic                               cursor_shown_o
);
  import atre_pkg::*;

  localparam int PIDX_W    = $clog2(MAX_PARAMS);
  localparam int PCNT_W    = $clog2(MAX_PARAMS + 1);
  localparam int TEXT_ROWS = SCREEN_ROWS - 1;
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [COL_W-1:0]  TAB_LIMIT = COL_W'(SCREEN_COLUMNS - 7);
  localparam logic [PCNT_W-1:0] PCNT_MAX  = PCNT_W'(MAX_PARAMS);
  localparam logic [15:0]       ROWS16    = 16'(TEXT_ROWS);
  localparam logic [15:0]       COLS16    = 16'(SCREEN_COLUMNS);

  // ---------------------------------------------------------------- config
  logic        aw_q, bse_q, crlf_q, lfcr_q;
  logic [7:0]  nfg_q, nbg_q;
  logic [63:0] pal_q;
  logic        cfg_we;
  reg_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q   <= 1'b1;
      bse_q  <= 1'b0;
      crlf_q <= 1'b0;
      lfcr_q <= 1'b0;
      nfg_q  <= NORM_FG_RST;
      nbg_q  <= NORM_BG_RST;
      pal_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_AUTOWRAP: aw_q   <= pwdata[0];
        REG_BS_ERASE: bse_q  <= pwdata[0];
        REG_CR_LF:    crlf_q <= pwdata[0];
        REG_LF_CR:    lfcr_q <= pwdata[0];
        REG_NORM_FG:  nfg_q  <= pwdata[7:0];
        REG_NORM_BG:  nbg_q  <= pwdata[7:0];
        REG_PALETTE:  pal_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_AUTOWRAP: prdata = 64'(aw_q);
      REG_BS_ERASE: prdata = 64'(bse_q);
      REG_CR_LF:    prdata = 64'(crlf_q);
      REG_LF_CR:    prdata = 64'(lfcr_q);
      REG_NORM_FG:  prdata = 64'(nfg_q);
      REG_NORM_BG:  prdata = 64'(nbg_q);
      REG_PALETTE:  prdata = pal_q;
      default:      prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- pipeline
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  logic       advance, fire, accept;

  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept)    in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire)         out_vld_q <= 1'b1;
      else if (advance) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byte_q <= rx_byte_i;
  end

  // ---------------------------------------------------------- engine state
  phase_e            phase_q, phase_nx;
  logic [15:0]       prm_q [MAX_PARAMS];
  logic [15:0]       prm_d [MAX_PARAMS];
  logic [PCNT_W-1:0] pidx_q, pidx_d;
  logic              priv_q, priv_d;
  logic [COL_W-1:0]  col_q, col_d, scol_q, scol_d;
  logic [ROW_W-1:0]  row_q, row_d, srow_q, srow_d;
  logic [7:0]        fg_q, fg_d, bg_q, bg_d;
  logic              vis_q, vis_d;

  // result of this byte
  action_e           act_d;
  logic [7:0]        glyph_d;
  logic [COL_W-1:0]  dcol_d;
  logic [ROW_W-1:0]  drow_d, scroll_d;

  // helpers
  logic [7:0]        b;
  logic              is_digit, is_final, is_print, prm_room;
  logic [15:0]       p0, p1, p2, n, prm_cur;
  logic [19:0]       acc;
  logic [16:0]       row_sum, col_sum;
  logic [COL_W:0]    tab_sum, tab_tgt;
  logic [2:0]        fg_pal, bg_pal;
  logic [ROW_W-1:0]  nl_row;
  logic              nl_scroll;

  assign b        = byte_q;
  assign is_digit = (b >= CH_DIG0) && (b <= CH_DIG9);
  assign is_final = (b >= CH_FINAL) && (b < CH_TILDE);
  assign is_print = (b >= CH_SPACE) && (b < 8'h7F);
  assign prm_room = pidx_q < PCNT_MAX;
  assign p0       = prm_q[0];
  assign p1       = prm_q[1];
  assign p2       = prm_q[2];
  assign n        = (p0 == 16'd0) ? 16'd1 : p0;
  assign prm_cur  = prm_q[pidx_q[PIDX_W-1:0]];
  assign acc      = 20'(prm_cur) * 20'd10 + 20'(b[3:0]);
  assign row_sum  = 17'(row_q) + 17'(n);
  assign col_sum  = 17'(col_q) + 17'(n);
  assign tab_sum  = {1'b0, col_q} + (COL_W + 1)'(8);
  assign tab_tgt  = tab_sum & ~(COL_W + 1)'(7);
  assign fg_pal   = 3'(p0 - PV_FG_LO);
  assign bg_pal   = 3'(p0 - PV_BG_LO);

  // one line down, or scroll at the bottom text row
  assign nl_scroll = (row_q >= LAST_ROW);
  assign nl_row    = nl_scroll ? row_q : row_q + ROW_W'(1);

  // parser phase
  always_comb begin
    phase_nx = phase_q;
    unique case (phase_q)
      PH_TEXT: phase_nx = (b == CH_ESC) ? PH_ESC : PH_TEXT;
      PH_ESC:  phase_nx = (b == CH_LBRK) ? PH_CSI : PH_TEXT;
      PH_CSI:  phase_nx = is_final ? PH_TEXT : PH_CSI;
      default: phase_nx = PH_TEXT;
    endcase
  end

  // datapath and result
  always_comb begin
    for (int i = 0; i < MAX_PARAMS; i++) prm_d[i] = prm_q[i];
    pidx_d   = pidx_q;
    priv_d   = priv_q;
    col_d    = col_q;
    row_d    = row_q;
    scol_d   = scol_q;
    srow_d   = srow_q;
    fg_d     = fg_q;
    bg_d     = bg_q;
    vis_d    = vis_q;
    act_d    = ACT_NONE;
    glyph_d  = '0;
    dcol_d   = '0;
    drow_d   = '0;
    scroll_d = '0;

    unique case (phase_q)
      PH_ESC: begin
        for (int i = 0; i < MAX_PARAMS; i++) prm_d[i] = '0;
        pidx_d = '0;
        priv_d = 1'b0;
      end

      PH_CSI: begin
        priority if (is_digit) begin
          if (prm_room) begin
            prm_d[pidx_q[PIDX_W-1:0]] = (acc > 20'(PV_SAT)) ? PV_SAT : acc[15:0];
          end
        end else if (b == CH_SEMI) begin
          if (prm_room) pidx_d = pidx_q + PCNT_W'(1);
        end else if (b == CH_QMARK) begin
          priv_d = 1'b1;
        end else if (is_final) begin
          unique case (b)
            FN_CUU: row_d = (n > 16'(row_q)) ? '0 : ROW_W'(16'(row_q) - n);
            FN_CUD: row_d = (row_sum > 17'(LAST_ROW)) ? LAST_ROW : ROW_W'(row_sum);
            FN_CUF: col_d = (col_sum > 17'(LAST_COL)) ? LAST_COL : COL_W'(col_sum);
            FN_CUB: col_d = (n > 16'(col_q)) ? '0 : COL_W'(16'(col_q) - n);
            FN_CUP: begin
              priority if (p0 <= 16'd1)  row_d = '0;
              else if (p0 > ROWS16)      row_d = LAST_ROW;
              else                       row_d = ROW_W'(p0 - 16'd1);
              priority if (p1 <= 16'd1)  col_d = '0;
              else if (p1 > COLS16)      col_d = LAST_COL;
              else                       col_d = COL_W'(p1 - 16'd1);
            end
            FN_EL: begin
              priority if (p0 == 16'd0) begin
                act_d  = ACT_CLR_EOL;
                dcol_d = col_q;
                drow_d = row_q;
              end else if (p0 == 16'd1) begin
                act_d  = ACT_CLR_BOL;
                drow_d = row_q;
              end else if (p0 == 16'd2) begin
                act_d  = ACT_CLR_LINE;
                drow_d = row_q;
              end else begin
                // unknown erase code: no action
              end
            end
            FN_ED: begin
              priority if (p0 == 16'd0) begin
                act_d  = ACT_CLR_EOS;
                dcol_d = col_q;
                drow_d = row_q;
              end else if (p0 == 16'd1) begin
                act_d = ACT_CLR_BOS;
              end else if (p0 == 16'd2 || p0 == 16'd3) begin
                act_d = ACT_CLR_SCRN;
                col_d = '0;
                row_d = '0;
              end else begin
                // unknown erase code: no action
              end
            end
            FN_SU: begin
              if (n >= ROWS16) act_d = ACT_CLR_SCRN;
              else             scroll_d = ROW_W'(n);
            end
            FN_SM: if (priv_q && p0 == PV_CURSOR) vis_d = 1'b1;
            FN_RM: if (priv_q && p0 == PV_CURSOR) vis_d = 1'b0;
            FN_SGR: begin
              priority if (p0 == 16'd0) begin
                fg_d = nfg_q;
                bg_d = nbg_q;
              end else if (p0 == PV_REVERSE) begin
                fg_d = bg_q;
                bg_d = fg_q;
              end else if (p0 >= PV_FG_LO && p0 <= PV_FG_HI) begin
                fg_d = pal_q[{fg_pal, 3'b000} +: 8];
              end else if (p0 == PV_FG_EXT && p1 == PV_IDX_MODE) begin
                fg_d = p2[7:0];
              end else if (p0 >= PV_BG_LO && p0 <= PV_BG_HI) begin
                bg_d = pal_q[{bg_pal, 3'b000} +: 8];
              end else if (p0 == PV_BG_EXT && p1 == PV_IDX_MODE) begin
                bg_d = p2[7:0];
              end else begin
                // unknown SGR code: colors kept
              end
            end
            FN_SCP: begin
              scol_d = col_q;
              srow_d = row_q;
            end
            FN_RCP: begin
              col_d = scol_q;
              row_d = srow_q;
            end
            default: ;
          endcase
          for (int i = 0; i < MAX_PARAMS; i++) prm_d[i] = '0;
          pidx_d = '0;
          priv_d = 1'b0;
        end else begin
          // other bytes inside a sequence are ignored
        end
      end

      default: begin // text
        priority if (is_print) begin
          act_d   = ACT_DRAW;
          glyph_d = b;
          dcol_d  = col_q;
          drow_d  = row_q;
          if (col_q < LAST_COL) begin
            col_d = col_q + COL_W'(1);
          end else if (aw_q) begin
            col_d    = '0;
            row_d    = nl_row;
            scroll_d = ROW_W'(nl_scroll);
          end
        end else if (b == CH_BEL) begin
          act_d = ACT_BEEP;
        end else if (b == CH_BS) begin
          col_d = (col_q != '0) ? col_q - COL_W'(1) : col_q;
          if (bse_q) begin
            act_d   = ACT_DRAW;
            glyph_d = CH_SPACE;
            dcol_d  = col_d;
            drow_d  = row_q;
          end
        end else if (b == CH_HT) begin
          if (col_q < TAB_LIMIT) begin
            col_d = (tab_tgt > {1'b0, LAST_COL}) ? LAST_COL : COL_W'(tab_tgt);
          end
        end else if (b == CH_CR) begin
          col_d = '0;
          if (crlf_q) begin
            row_d    = nl_row;
            scroll_d = ROW_W'(nl_scroll);
          end
        end else if (b == CH_LF) begin
          if (lfcr_q) col_d = '0;
          row_d    = nl_row;
          scroll_d = ROW_W'(nl_scroll);
        end else if (b == CH_FF) begin
          act_d = ACT_CLR_SCRN;
          col_d = '0;
          row_d = '0;
        end else begin
          // ESC and bytes without meaning: no action
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      for (int i = 0; i < MAX_PARAMS; i++) prm_q[i] <= '0;
      pidx_q  <= '0;
      priv_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      scol_q  <= '0;
      srow_q  <= '0;
      fg_q    <= NORM_FG_RST;
      bg_q    <= NORM_BG_RST;
      vis_q   <= 1'b1;
    end else if (fire) begin
      phase_q <= phase_nx;
      for (int i = 0; i < MAX_PARAMS; i++) prm_q[i] <= prm_d[i];
      pidx_q  <= pidx_d;
      priv_q  <= priv_d;
      col_q   <= col_d;
      row_q   <= row_d;
      scol_q  <= scol_d;
      srow_q  <= srow_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      vis_q   <= vis_d;
    end
  end

  // ------------------------------------------------------- result register
  action_e          res_act_q;
  logic [7:0]       res_glyph_q, res_fg_q, res_bg_q;
  logic [COL_W-1:0] res_dcol_q, res_col_q;
  logic [ROW_W-1:0] res_drow_q, res_row_q, res_scroll_q;
  logic             res_vis_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_act_q    <= act_d;
      res_glyph_q  <= glyph_d;
      res_dcol_q   <= dcol_d;
      res_drow_q   <= drow_d;
      res_fg_q     <= fg_d;
      res_bg_q     <= bg_d;
      res_scroll_q <= scroll_d;
      res_col_q    <= col_d;
      res_row_q    <= row_d;
      res_vis_q    <= vis_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign action_o       = res_act_q;
  assign glyph_o        = res_glyph_q;
  assign draw_col_o     = res_dcol_q;
  assign draw_row_o     = res_drow_q;
  assign draw_fg_o      = res_fg_q;
  assign draw_bg_o      = res_bg_q;
  assign scroll_lines_o = res_scroll_q;
  assign cursor_col_o   = res_col_q;
  assign cursor_row_o   = res_row_q;
  assign cursor_shown_o = res_vis_q;

  // ------------------------------------------------------------ assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result path free");

  a_glyph_only_on_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o != ACT_DRAW) |-> (glyph_o == 8'd0))
    else $error("glyph set on non-draw action");

  a_cursor_in_text_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= LAST_ROW) && (col_q <= LAST_COL))
    else $error("cursor outside text area");

  a_esc_seq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ESC) |-> (pidx_q == '0 && !priv_q))
    else $error("sequence state not cleared after ESC");

endmodule

`default_nettype wire

### tb/sv/screen_checker.sv
`timescale 1ns / 1ps

// Watches both word channels and the APB port, predicts each screen word
// from the bytes taken in, and compares every field of the words given out.
module screen_checker #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 30,
  parameter int MAX_PARAMS     = 5,
  localparam int COL_W = $clog2(SCREEN_COLUMNS),
  localparam int ROW_W = $clog2(SCREEN_ROWS)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [atre_pkg::CFG_AW-1:0]   paddr,
  input  wire  [atre_pkg::CFG_DW-1:0]   pwdata,
  input  wire                           pready,
  input  wire                           in_valid_i,
  input  wire                           in_stall_i,
  input  wire  [7:0]                    rx_byte_i,
  input  wire                           out_valid_i,
  input  wire                           out_stall_i,
  input  wire  [atre_pkg::ACTION_W-1:0] action_i,
  input  wire  [7:0]                    glyph_i,
  input  wire  [COL_W-1:0]              draw_col_i,
  input  wire  [ROW_W-1:0]              draw_row_i,
  input  wire  [7:0]                    draw_fg_i,
  input  wire  [7:0]                    draw_bg_i,
  input  wire  [ROW_W-1:0]              scroll_lines_i,
  input  wire  [COL_W-1:0]              cursor_col_i,
  input  wire  [ROW_W-1:0]              cursor_row_i,
  input  wire                           cursor_shown_i,
  output int                            errors_o,
  output int                            pending_o
);
  import atre_pkg::*;

  localparam int TEXT_ROWS = SCREEN_ROWS - 1;

  typedef struct packed {
    action_e          action;
    logic [7:0]       glyph;
    logic [COL_W-1:0] draw_col;
    logic [ROW_W-1:0] draw_row;
    logic [7:0]       draw_fg;
    logic [7:0]       draw_bg;
    logic [ROW_W-1:0] scroll_lines;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             cursor_shown;
  } screen_word_t;

  // register copies
  logic        wrap_en, bs_erase, cr_lf, lf_cr;
  logic [7:0]  norm_fg, norm_bg;
  logic [63:0] palette;

  // parser and screen state
  phase_e      phase;
  logic [15:0] csi_arg [MAX_PARAMS];
  int          arg_idx;
  logic        private_mode;
  int          col, row, saved_col, saved_row;
  logic [7:0]  fg, bg;
  logic        shown;
  int          scroll_now;

  screen_word_t expected_screen_q[$];
  int mismatch_count = 0;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  function automatic int clamp_to_range(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_csi();
    for (int i = 0; i < MAX_PARAMS; i++) csi_arg[i] = '0;
    arg_idx = 0;
    private_mode = 1'b0;
  endtask

  task automatic reset_model();
    wrap_en  = 1'b1;
    bs_erase = 1'b0;
    cr_lf    = 1'b0;
    lf_cr    = 1'b0;
    norm_fg  = NORM_FG_RST;
    norm_bg  = NORM_BG_RST;
    palette  = '0;
    phase    = PH_TEXT;
    clear_csi();
    col = 0; row = 0; saved_col = 0; saved_row = 0;
    fg = NORM_FG_RST;
    bg = NORM_BG_RST;
    shown = 1'b1;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      REG_AUTOWRAP: wrap_en  = d[0];
      REG_BS_ERASE: bs_erase = d[0];
      REG_CR_LF:    cr_lf    = d[0];
      REG_LF_CR:    lf_cr    = d[0];
      REG_NORM_FG:  norm_fg  = d[7:0];
      REG_NORM_BG:  norm_bg  = d[7:0];
      REG_PALETTE:  palette  = d;
      default: ;
    endcase
  endtask

  // line advance: scroll when already on the last text row
  task automatic next_line();
    if (row < TEXT_ROWS - 1) row++;
    else scroll_now = 1;
  endtask

  task automatic step_terminal(input logic [7:0] b, output screen_word_t w);
    action_e    act;
    logic [7:0] gl;
    logic [7:0] swap;
    int         dc, dr, p0, p1, n, v;
    act = ACT_NONE;
    gl = 8'h00;
    dc = 0;
    dr = 0;
    scroll_now = 0;
    p0 = int'(csi_arg[0]);
    p1 = int'(csi_arg[1]);
    n = (p0 == 0) ? 1 : p0;
    case (phase)
      PH_ESC: begin
        clear_csi();
        phase = (b == CH_LBRK) ? PH_CSI : PH_TEXT;
      end
      PH_CSI: begin
        if (b >= CH_DIG0 && b <= CH_DIG9) begin
          if (arg_idx < MAX_PARAMS) begin
            v = int'(csi_arg[arg_idx]) * 10 + int'(b) - int'(CH_DIG0);
            csi_arg[arg_idx] = (v > int'(PV_SAT)) ? PV_SAT : 16'(v);
          end
        end else if (b == CH_SEMI) begin
          if (arg_idx < MAX_PARAMS) arg_idx++;
        end else if (b == CH_QMARK) begin
          private_mode = 1'b1;
        end else if (b >= CH_FINAL && b < CH_TILDE) begin
          case (b)
            FN_CUU: row = clamp_to_range(row - n, TEXT_ROWS - 1);
            FN_CUD: row = clamp_to_range(row + n, TEXT_ROWS - 1);
            FN_CUF: col = clamp_to_range(col + n, SCREEN_COLUMNS - 1);
            FN_CUB: col = clamp_to_range(col - n, SCREEN_COLUMNS - 1);
            FN_CUP: begin
              row = clamp_to_range(p0 - 1, TEXT_ROWS - 1);
              col = clamp_to_range(p1 - 1, SCREEN_COLUMNS - 1);
            end
            FN_EL: begin
              if (p0 == 0) begin
                act = ACT_CLR_EOL; dc = col; dr = row;
              end else if (p0 == 1) begin
                act = ACT_CLR_BOL; dr = row;
              end else if (p0 == 2) begin
                act = ACT_CLR_LINE; dr = row;
              end
            end
            FN_ED: begin
              if (p0 == 0) begin
                act = ACT_CLR_EOS; dc = col; dr = row;
              end else if (p0 == 1) begin
                act = ACT_CLR_BOS;
              end else if (p0 == 2 || p0 == 3) begin
                act = ACT_CLR_SCRN; col = 0; row = 0;
              end
            end
            FN_SU: begin
              if (n >= TEXT_ROWS) act = ACT_CLR_SCRN;
              else scroll_now = n;
            end
            FN_SM: if (private_mode && p0 == int'(PV_CURSOR)) shown = 1'b1;
            FN_RM: if (private_mode && p0 == int'(PV_CURSOR)) shown = 1'b0;
            FN_SGR: begin
              if (p0 == 0) begin
                fg = norm_fg; bg = norm_bg;
              end else if (p0 == int'(PV_REVERSE)) begin
                swap = fg; fg = bg; bg = swap;
              end else if (p0 >= int'(PV_FG_LO) && p0 <= int'(PV_FG_HI)) begin
                fg = palette[8*(p0 - int'(PV_FG_LO)) +: 8];
              end else if (p0 == int'(PV_FG_EXT) && p1 == int'(PV_IDX_MODE)) begin
                fg = csi_arg[2][7:0];
              end else if (p0 >= int'(PV_BG_LO) && p0 <= int'(PV_BG_HI)) begin
                bg = palette[8*(p0 - int'(PV_BG_LO)) +: 8];
              end else if (p0 == int'(PV_BG_EXT) && p1 == int'(PV_IDX_MODE)) begin
                bg = csi_arg[2][7:0];
              end
            end
            FN_SCP: begin
              saved_col = col; saved_row = row;
            end
            FN_RCP: begin
              col = saved_col; row = saved_row;
            end
            default: ;
          endcase
          clear_csi();
          phase = PH_TEXT;
        end
        // anything else inside a sequence is dropped
      end
      default: begin
        phase = PH_TEXT;
        if (b >= CH_SPACE && b <= CH_TILDE) begin
          act = ACT_DRAW; gl = b; dc = col; dr = row;
          if (col < SCREEN_COLUMNS - 1) begin
            col++;
          end else if (wrap_en) begin
            col = 0;
            next_line();
          end
        end else if (b == CH_ESC) begin
          phase = PH_ESC;
        end else begin
          case (b)
            CH_BEL: act = ACT_BEEP;
            CH_BS: begin
              if (col > 0) col--;
              if (bs_erase) begin
                act = ACT_DRAW; gl = CH_SPACE; dc = col; dr = row;
              end
            end
            CH_HT: begin
              // next multiple of 8; nothing near the right edge
              if (col < SCREEN_COLUMNS - 7)
                col = clamp_to_range((col / 8 + 1) * 8, SCREEN_COLUMNS - 1);
            end
            CH_CR: begin
              col = 0;
              if (cr_lf) next_line();
            end
            CH_LF: begin
              if (lf_cr) col = 0;
              next_line();
            end
            CH_FF: begin
              act = ACT_CLR_SCRN; col = 0; row = 0;
            end
            default: ;
          endcase
        end
      end
    endcase
    w.action       = act;
    w.glyph        = gl;
    w.draw_col     = COL_W'(dc);
    w.draw_row     = ROW_W'(dr);
    w.draw_fg      = fg;
    w.draw_bg      = bg;
    w.scroll_lines = ROW_W'(scroll_now);
    w.cursor_col   = COL_W'(col);
    w.cursor_row   = ROW_W'(row);
    w.cursor_shown = shown;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    screen_word_t got_w, want_w;
    if (!rst_ni) begin
      reset_model();
      expected_screen_q.delete();
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[5:3], pwdata);
      if (out_valid_i && !out_stall_i) begin
        got_w.action       = action_e'(action_i);
        got_w.glyph        = glyph_i;
        got_w.draw_col     = draw_col_i;
        got_w.draw_row     = draw_row_i;
        got_w.draw_fg      = draw_fg_i;
        got_w.draw_bg      = draw_bg_i;
        got_w.scroll_lines = scroll_lines_i;
        got_w.cursor_col   = cursor_col_i;
        got_w.cursor_row   = cursor_row_i;
        got_w.cursor_shown = cursor_shown_i;
        if (expected_screen_q.size() == 0) begin
          report_mismatch("word with nothing expected, action", got_w.action, 0);
        end else begin
          want_w = expected_screen_q.pop_front();
          check_field("action", got_w.action, want_w.action);
          check_field("glyph", got_w.glyph, want_w.glyph);
          check_field("draw_col", got_w.draw_col, want_w.draw_col);
          check_field("draw_row", got_w.draw_row, want_w.draw_row);
          check_field("draw_fg", got_w.draw_fg, want_w.draw_fg);
          check_field("draw_bg", got_w.draw_bg, want_w.draw_bg);
          check_field("scroll_lines", got_w.scroll_lines, want_w.scroll_lines);
          check_field("cursor_col", got_w.cursor_col, want_w.cursor_col);
          check_field("cursor_row", got_w.cursor_row, want_w.cursor_row);
          check_field("cursor_shown", got_w.cursor_shown, want_w.cursor_shown);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_terminal(rx_byte_i, want_w);
        expected_screen_q.push_back(want_w);
      end
      pending_o = expected_screen_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the bench: clock, one reset, APB setup between phases and the
// byte stream. All prediction and comparison lives in screen_checker.
module tb;
  import atre_pkg::*;

  localparam int COLS  = 80;
  localparam int ROWS  = 30;
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_W = $clog2(ROWS);

  // address slot past the last register; writes there must do nothing
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // random phases after the directed opener, bytes per phase
  localparam int NUM_PHASES = 6;
  localparam int PHASE_BYTES = 150;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                psel, penable, pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ACTION_W-1:0] action_o;
  logic [7:0]          glyph_o;
  logic [COL_W-1:0]    draw_col_o;
  logic [ROW_W-1:0]    draw_row_o;
  logic [7:0]          draw_fg_o;
  logic [7:0]          draw_bg_o;
  logic [ROW_W-1:0]    scroll_lines_o;
  logic [COL_W-1:0]    cursor_col_o;
  logic [ROW_W-1:0]    cursor_row_o;
  logic                cursor_shown_o;

  int mismatches;
  int pending;

  int burst_left = 0;   // words left in the current sender burst
  int bytes_sent = 0;   // accepted input words so far
  int hold_len   = 0;   // request for a long receiver hold-off, in cycles

  ansi_terminal_rx_engine_core #(
    .SCREEN_COLUMNS (COLS),
    .SCREEN_ROWS    (ROWS),
    .MAX_PARAMS     (5)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .glyph_o        (glyph_o),
    .draw_col_o     (draw_col_o),
    .draw_row_o     (draw_row_o),
    .draw_fg_o      (draw_fg_o),
    .draw_bg_o      (draw_bg_o),
    .scroll_lines_o (scroll_lines_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_shown_o (cursor_shown_o)
  );

  screen_checker #(
    .SCREEN_COLUMNS (COLS),
    .SCREEN_ROWS    (ROWS),
    .MAX_PARAMS     (5)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_i       (action_o),
    .glyph_i        (glyph_o),
    .draw_col_i     (draw_col_o),
    .draw_row_i     (draw_row_o),
    .draw_fg_i      (draw_fg_o),
    .draw_bg_i      (draw_bg_o),
    .scroll_lines_i (scroll_lines_o),
    .cursor_col_i   (cursor_col_o),
    .cursor_row_i   (cursor_row_o),
    .cursor_shown_i (cursor_shown_o),
    .errors_o       (mismatches),
    .pending_o      (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side. Picks a stall pattern for a random stretch, then another;
  // STALL_NONE stretches give runs with no back-pressure at all. A nonzero
  // hold_len overrides everything and holds stall high for the length it asks,
  // counted here so the sender keeps offering words meanwhile.
  initial begin : rx_stall_gen
    stall_mode_e mode;
    int left;
    int k;
    out_stall_i = 1'b0;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        for (k = 1; k < hold_len; k++) @(negedge clk_i);
        hold_len = 0;
      end else begin
        if (left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          left = $urandom_range(8, 60);
        end
        left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // All driving tasks are entered and left at a falling edge.

  // APB write: setup cycle, access cycle, then an idle cycle so back-to-back
  // writes never touch psel twice in the same step.
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one word. Bursts of random length with random gaps between;
  // inside a burst valid stays high from word to word.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  // Drain: drop valid, wait for every expected word, then let the bench idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // one parameter field, biased toward values the decoder cares about
  task automatic send_param();
    case ($urandom_range(0, 6))
      0: ;  // empty field, counts as 0
      1: send_number($urandom_range(0, 3));
      2: send_number($urandom_range(0, 99));
      3: begin
        case ($urandom_range(0, 5))
          0: send_number(PV_REVERSE);
          1: send_number(PV_CURSOR);
          2: send_number($urandom_range(PV_FG_LO, PV_FG_HI));
          3: send_number($urandom_range(PV_BG_LO, PV_BG_HI));
          4: send_number(PV_FG_EXT);
          default: send_number(PV_BG_EXT);
        endcase
      end
      4: send_number($urandom_range(ROWS - 3, ROWS + 2));
      5: send_number($urandom_range(COLS - 2, COLS + 2));
      // long digit run: can saturate the field
      default: repeat ($urandom_range(5, 9)) send_byte(8'($urandom_range(CH_DIG0, CH_DIG9)));
    endcase
  endtask

  function automatic logic [7:0] pick_final();
    case ($urandom_range(0, 15))
      0:  return FN_CUU;
      1:  return FN_CUD;
      2:  return FN_CUF;
      3:  return FN_CUB;
      4:  return FN_CUP;
      5:  return FN_ED;
      6:  return FN_EL;
      7:  return FN_SU;
      8:  return FN_SM;
      9:  return FN_RM;
      10: return FN_SGR;
      11: return FN_SCP;
      12: return FN_RCP;
      13: return FN_SGR;
      default: return 8'($urandom_range(CH_FINAL, CH_TILDE - 8'd1));
    endcase
  endfunction

  // bytes the parser drops while inside a sequence
  function automatic logic [7:0] pick_junk();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, CH_DIG0 - 8'd1));
      1: return CH_DIG9 + 8'd1;
      2: return 8'($urandom_range(CH_SEMI + 8'd1, CH_QMARK - 8'd1));
      3: return CH_TILDE;
      default: return 8'($urandom_range(CH_TILDE + 8'd1, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 5))
      0: return CH_BEL;
      1: return CH_BS;
      2: return CH_HT;
      3: return CH_CR;
      4: return CH_LF;
      default: return CH_FF;
    endcase
  endfunction

  // ESC [ [?] params... final, or the indexed-color SGR form
  task automatic send_csi(input bit with_final);
    int count;
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    if ($urandom_range(0, 4) == 0) send_byte(CH_QMARK);
    if (with_final && $urandom_range(0, 5) == 0) begin
      send_number($urandom_range(0, 1) ? PV_FG_EXT : PV_BG_EXT);
      send_byte(CH_SEMI);
      send_number(PV_IDX_MODE);
      send_byte(CH_SEMI);
      send_number($urandom_range(0, 255));
      send_byte(FN_SGR);
    end else begin
      // up to 7 fields: more than the block keeps
      count = $urandom_range(0, 7);
      for (int i = 0; i < count; i++) begin
        if (i > 0) send_byte(CH_SEMI);
        send_param();
        if ($urandom_range(0, 7) == 0) send_byte(pick_junk());
      end
      if (with_final) send_byte(pick_final());
    end
  endtask

  task automatic send_random_item();
    int sel;
    int len;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      send_csi(1'b1);
    end else if (sel < 62) begin
      // text; long runs hit the right edge and the wrap
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 12);
      repeat (len) send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
    end else if (sel < 77) begin
      // repeated controls walk the cursor to the bottom or the left edge
      b = pick_control();
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, ROWS + 2) : 1;
      repeat (len) send_byte(b);
    end else if (sel < 82) begin
      // ESC and anything but '['
      b = 8'($urandom);
      if (b == CH_LBRK) b = CH_ESC;
      send_byte(CH_ESC);
      send_byte(b);
    end else if (sel < 92) begin
      send_byte(8'($urandom));
    end else begin
      // broken sequence: whatever follows gets parsed as its tail
      send_csi(1'b0);
    end
  endtask

  task automatic configure_phase(input int ph);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (ph)
      0: begin
        apb_write(REG_AUTOWRAP, {r[63:1], 1'b0});
        apb_write(REG_BS_ERASE, {r[63:1], 1'b1});
        apb_write(REG_CR_LF,    {r[63:1], 1'b1});
        apb_write(REG_LF_CR,    {r[63:1], 1'b1});
        apb_write(REG_NORM_FG,  {r[63:8], 8'h00});
        apb_write(REG_NORM_BG,  {r[63:8], 8'hFF});
        apb_write(REG_PALETTE,  '1);
        apb_write(REG_UNUSED,   r);
      end
      1: begin
        apb_write(REG_AUTOWRAP, 64'd1);
        apb_write(REG_BS_ERASE, 64'd0);
        apb_write(REG_CR_LF,    64'd0);
        apb_write(REG_LF_CR,    64'd0);
        apb_write(REG_NORM_FG,  64'hFF);
        apb_write(REG_NORM_BG,  64'h00);
        apb_write(REG_PALETTE,  64'd0);
      end
      default: begin
        apb_write(REG_AUTOWRAP, {$urandom, $urandom});
        apb_write(REG_BS_ERASE, {$urandom, $urandom});
        apb_write(REG_CR_LF,    {$urandom, $urandom});
        apb_write(REG_LF_CR,    {$urandom, $urandom});
        apb_write(REG_NORM_FG,  {$urandom, $urandom});
        apb_write(REG_NORM_BG,  {$urandom, $urandom});
        apb_write(REG_PALETTE,  {$urandom, $urandom});
      end
    endcase
  endtask

  initial begin : stimulus
    int target;
    int guard;
    bit held;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opener, reset config: both printable extremes, every control,
    // a saturating parameter that drives the cursor to the bottom, hiding
    // the cursor, a swallowed ESC, and bytes outside the printable range.
    send_byte(CH_TILDE);
    send_byte(CH_SPACE);
    send_byte(CH_BEL);
    send_byte(CH_BS);
    send_byte(CH_HT);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_FF);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_number(999999);
    send_byte(FN_CUD);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte(CH_QMARK);
    send_number(PV_CURSOR);
    send_byte(FN_RM);
    send_byte(CH_ESC);
    send_byte(CH_TILDE);
    send_byte(8'hFF);
    send_byte(8'h00);

    // Random phases, each with its own register setting. Registers change
    // only once the engine has drained. Halfway through each phase the
    // receiver holds off long enough to back the engine up into its input.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      configure_phase(ph);
      target = bytes_sent + PHASE_BYTES;
      held = 1'b0;
      while (bytes_sent < target) begin
        if (!held && bytes_sent >= target - PHASE_BYTES / 2) begin
          hold_len = $urandom_range(40, 90);
          held = 1'b1;
        end
        send_random_item();
      end
    end

    // drain with a bound; anything still expected after it is a failure
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### ansi_terminal_rx_engine_core.f
rtl/atre_pkg.sv
rtl/ansi_terminal_rx_engine_core.sv
tb/sv/screen_checker.sv
tb/sv/tb.sv
